// ----- rtl/core/exprtok_pkg.sv -----
// Shared types, constants and helper functions for the expression tokenizer.
// No dependencies; used by exprtok_lexer, exprtok_queue and the top level.
`timescale 1ns / 1ps

package exprtok_pkg;

    localparam int POSITION_BITS = 32;
    localparam int LENGTH_BITS   = 16;
    localparam int KW_LEN        = 5;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        TOK_IDENT     = 4'd0,
        TOK_LET       = 4'd1,
        TOK_PRINT     = 4'd2,
        TOK_RPAREN    = 4'd3,
        TOK_LPAREN    = 4'd4,
        TOK_PLUS      = 4'd5,
        TOK_MINUS     = 4'd6,
        TOK_EQUAL     = 4'd7,
        TOK_STAR      = 4'd8,
        TOK_SLASH     = 4'd9,
        TOK_SEMICOLON = 4'd10,
        TOK_NUMBER    = 4'd11,
        TOK_END       = 4'd12,
        TOK_UNKNOWN   = 4'd13
    } tok_kind_t;

    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_WORD   = 2'd1,
        RUN_NUMBER = 2'd2
    } run_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] start;
        logic [15:0] length;
        logic [7:0]  chr;
        logic        last;
    } tok_result_t;

    // keyword spellings, one byte per index
    function automatic logic [7:0] kw_let_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h6D; // m
            3'd1:    c = 8'h61; // a
            3'd2:    c = 8'h6E; // n
            3'd3:    c = 8'h6C; // l
            3'd4:    c = 8'h6F; // o
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_print_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h63; // c
            3'd1:    c = 8'h68; // h
            3'd2:    c = 8'h61; // a
            3'd3:    c = 8'h70; // p
            3'd4:    c = 8'h6F; // o
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic tok_kind_t symbol_kind(input logic [7:0] c);
        tok_kind_t k;
        case (c)
            8'h29:   k = TOK_RPAREN;
            8'h28:   k = TOK_LPAREN;
            8'h2B:   k = TOK_PLUS;
            8'h2D:   k = TOK_MINUS;
            8'h3D:   k = TOK_EQUAL;
            8'h2A:   k = TOK_STAR;
            8'h2F:   k = TOK_SLASH;
            8'h3B:   k = TOK_SEMICOLON;
            default: k = TOK_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] sat_start(input logic [POSITION_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [15:0] sat_length(input logic [LENGTH_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

// ----- rtl/core/exprtok_lexer.sv -----
// Per-byte lexer: run state registers plus the logic that forms up to two tokens.
// Depends on exprtok_pkg.
`timescale 1ns / 1ps

module exprtok_lexer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      op,
    input  logic [7:0]                char_in,
    output exprtok_pkg::tok_result_t  res0,
    output exprtok_pkg::tok_result_t  res1,
    output logic [1:0]                res_cnt
);

    localparam logic [exprtok_pkg::POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [exprtok_pkg::LENGTH_BITS-1:0]   LEN_MAX = '1;
    localparam logic [exprtok_pkg::LENGTH_BITS-1:0]   KW_LEN_L =
        exprtok_pkg::LENGTH_BITS'(exprtok_pkg::KW_LEN);

    exprtok_pkg::run_kind_t                 run_kind_reg, run_kind_next;
    logic [exprtok_pkg::POSITION_BITS-1:0]  run_start_reg, run_start_next;
    logic [exprtok_pkg::LENGTH_BITS-1:0]    run_length_reg, run_length_next;
    logic [exprtok_pkg::POSITION_BITS-1:0]  position_reg, position_next;
    logic                                   let_match_reg, let_match_next;
    logic                                   print_match_reg, print_match_next;

    logic                      alpha, digit, space, is_sym;
    exprtok_pkg::run_kind_t    want;
    logic                      close_run;
    logic                      in_kw;
    logic [2:0]                kw_idx;
    exprtok_pkg::tok_result_t  run_tok, second_tok;
    logic                      has_second;

    always_comb
    begin
        alpha  = (char_in >= 8'h61 && char_in <= 8'h7A) || (char_in >= 8'h41 && char_in <= 8'h5A);
        digit  = (char_in >= 8'h30 && char_in <= 8'h39);
        space  = (char_in == 8'h20) || (char_in >= 8'h09 && char_in <= 8'h0D);
        is_sym = !alpha && !digit && !space;
        want   = alpha ? exprtok_pkg::RUN_WORD : exprtok_pkg::RUN_NUMBER;

        close_run = (run_kind_reg != exprtok_pkg::RUN_NONE) &&
                    (op || !(alpha || digit) || run_kind_reg != want);

        in_kw  = run_length_reg < KW_LEN_L;
        kw_idx = in_kw ? run_length_reg[2:0] : 3'd0;
    end

    // token for the run being closed
    always_comb
    begin
        run_tok.start  = exprtok_pkg::sat_start(run_start_reg);
        run_tok.length = exprtok_pkg::sat_length(run_length_reg);
        run_tok.chr    = 8'h00;
        run_tok.last   = 1'b0;
        if (run_kind_reg == exprtok_pkg::RUN_NUMBER)
            run_tok.kind = exprtok_pkg::TOK_NUMBER;
        else if (let_match_reg && run_length_reg == KW_LEN_L)
            run_tok.kind = exprtok_pkg::TOK_LET;
        else if (print_match_reg && run_length_reg == KW_LEN_L)
            run_tok.kind = exprtok_pkg::TOK_PRINT;
        else
            run_tok.kind = exprtok_pkg::TOK_IDENT;
    end

    // end, symbol or unknown token caused by the byte itself
    always_comb
    begin
        second_tok.start = exprtok_pkg::sat_start(position_reg);
        second_tok.last  = 1'b1;
        if (op)
        begin
            second_tok.kind   = exprtok_pkg::TOK_END;
            second_tok.length = 16'd0;
            second_tok.chr    = 8'h00;
        end
        else
        begin
            second_tok.kind   = exprtok_pkg::symbol_kind(char_in);
            second_tok.length = 16'd1;
            second_tok.chr    = char_in;
        end
        has_second = op || is_sym;
    end

    always_comb
    begin
        res1 = second_tok;
        if (close_run)
        begin
            res0      = run_tok;
            res0.last = !has_second;
            res_cnt   = has_second ? 2'd2 : 2'd1;
        end
        else
        begin
            res0    = second_tok;
            res_cnt = has_second ? 2'd1 : 2'd0;
        end
    end

    always_comb
    begin
        run_kind_next    = run_kind_reg;
        run_start_next   = run_start_reg;
        run_length_next  = run_length_reg;
        position_next    = position_reg;
        let_match_next   = let_match_reg;
        print_match_next = print_match_reg;
        if (op)
        begin
            run_kind_next    = exprtok_pkg::RUN_NONE;
            run_start_next   = '0;
            run_length_next  = '0;
            position_next    = '0;
            let_match_next   = 1'b0;
            print_match_next = 1'b0;
        end
        else
        begin
            if (alpha || digit)
            begin
                if (run_kind_reg == want)
                begin
                    let_match_next   = let_match_reg && in_kw &&
                                       char_in == exprtok_pkg::kw_let_char(kw_idx);
                    print_match_next = print_match_reg && in_kw &&
                                       char_in == exprtok_pkg::kw_print_char(kw_idx);
                    if (run_length_reg != LEN_MAX)
                        run_length_next = run_length_reg + 1'b1;
                end
                else
                begin
                    run_kind_next    = want;
                    run_start_next   = position_reg;
                    run_length_next  = exprtok_pkg::LENGTH_BITS'(1);
                    let_match_next   = alpha && char_in == exprtok_pkg::kw_let_char(3'd0);
                    print_match_next = alpha && char_in == exprtok_pkg::kw_print_char(3'd0);
                end
            end
            else if (close_run)
            begin
                run_kind_next    = exprtok_pkg::RUN_NONE;
                run_length_next  = '0;
                let_match_next   = 1'b0;
                print_match_next = 1'b0;
            end
            if (position_reg != POS_MAX)
                position_next = position_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_kind_reg    <= exprtok_pkg::RUN_NONE;
            run_start_reg   <= '0;
            run_length_reg  <= '0;
            position_reg    <= '0;
            let_match_reg   <= 1'b0;
            print_match_reg <= 1'b0;
        end
        else if (accept)
        begin
            run_kind_reg    <= run_kind_next;
            run_start_reg   <= run_start_next;
            run_length_reg  <= run_length_next;
            position_reg    <= position_next;
            let_match_reg   <= let_match_next;
            print_match_reg <= print_match_next;
        end
    end

endmodule

// ----- rtl/core/exprtok_queue.sv -----
// Small result queue: takes up to two tokens a cycle, hands out one per request.
// Depends on exprtok_pkg.
`timescale 1ns / 1ps

module exprtok_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                push_cnt,
    input  exprtok_pkg::tok_result_t  push0,
    input  exprtok_pkg::tok_result_t  push1,
    output logic                      room2,
    output logic                      out_valid,
    input  logic                      out_ready,
    output exprtok_pkg::tok_result_t  head
);

    localparam int CW = exprtok_pkg::QUEUE_AW + 1;

    exprtok_pkg::tok_result_t          mem [exprtok_pkg::QUEUE_DEPTH];
    logic [exprtok_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [exprtok_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic                              pop;

    always_comb
    begin
        out_valid   = count_reg != '0;
        pop         = out_valid && out_ready;
        room2       = count_reg <= CW'(exprtok_pkg::QUEUE_DEPTH - 2);
        head        = mem[rd_ptr_reg];
        rd_ptr_next = rd_ptr_reg + exprtok_pkg::QUEUE_AW'(pop);
        wr_ptr_next = wr_ptr_reg + exprtok_pkg::QUEUE_AW'(push_cnt);
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem[wr_ptr_reg + 1'b1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/expression_language_tokenizer.sv -----
// Top level of the expression tokenizer: lexer state plus result queue.
// Depends on exprtok_pkg, exprtok_lexer and exprtok_queue.
//
//  channel | signals                                           | dir
//  --------+---------------------------------------------------+-----
//  input   | in_valid, in_ready, op, char_in                   | in
//  result  | out_valid, out_ready, token_kind, token_start,    | out
//          | token_length, token_char, last_result             |
//
// One byte or end request is taken per cycle while in_ready is high; its
// tokens (zero to two) are formed in the same cycle and land in a four-entry
// queue, first visible the next cycle. Results leave at one per cycle while
// out_ready is high. in_ready drops while the queue has fewer than two free
// entries. rst_n clears the lexer state and empties the queue.
`timescale 1ns / 1ps

module expression_language_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [31:0] token_start,
    output logic [15:0] token_length,
    output logic [7:0]  token_char,
    output logic        last_result
);

    logic                      accept;
    logic                      room2;
    logic [1:0]                res_cnt;
    logic [1:0]                push_cnt;
    exprtok_pkg::tok_result_t  res0, res1, head;

    assign accept   = in_valid && in_ready;
    assign in_ready = room2;
    assign push_cnt = accept ? res_cnt : 2'd0;

    exprtok_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (op),
        .char_in (char_in),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    exprtok_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign token_char   = head.chr;
    assign last_result  = head.last;

endmodule
